@@ hdl/cdd_pkg.sv @@
// Shared types, calendar tables and the divide-by-25 helper for the date difference block.
package cdd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned ShiftW = YearW + 1;  // year shifted by 400, March-based
  localparam int unsigned QuotW  = 8;          // year / 100 at the widest input
  localparam int unsigned Q400W  = 6;          // shifted year / 400
  localparam int unsigned NumW   = 23;         // day number and signed difference
  localparam int unsigned DivInW = 13;
  localparam int unsigned ProdW  = 24;

  localparam logic [YearW-1:0]  YearLimit   = YearW'(9999);
  localparam logic [MonthW-1:0] MonthFeb    = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec    = MonthW'(12);
  localparam logic [ShiftW-1:0] YearShift   = ShiftW'(400);
  localparam logic [ProdW-1:0]  Recip25     = ProdW'(1311);  // 2^15 / 25, rounded up
  localparam logic [NumW-1:0]   DaysPerYear = NumW'(365);

  // Stage 1 result for one date: raw fields plus the quotients needed later.
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [ShiftW-1:0] yy;         // year + 400, minus one for January and February
    logic [QuotW-1:0]  year_c100;  // year / 100
    logic [QuotW-1:0]  yy_c100;    // yy / 100
    logic [Q400W-1:0]  yy_c400;    // yy / 400
  } prep_t;

  // Stage 2 result for one date.
  typedef struct packed {
    logic [NumW-1:0] num;
    logic            ok;
  } daynum_t;

  // floor(x / 25) for x below 4200, by reciprocal multiply.
  function automatic logic [QuotW-1:0] div25(input logic [DivInW-1:0] x);
    logic [ProdW-1:0] prod;
    prod = ProdW'(x) * Recip25;
    return prod[22:15];
  endfunction

  // Days in a month of a common year; zero for codes that are no month.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return DayW'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    return DayW'(30);
      4'd2:                                       return DayW'(28);
      default:                                    return DayW'(0);
    endcase
  endfunction

  // Days before the first of the month in a year that starts in March.
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] m);
    case (m)
      4'd3:    return 9'd0;
      4'd4:    return 9'd31;
      4'd5:    return 9'd61;
      4'd6:    return 9'd92;
      4'd7:    return 9'd122;
      4'd8:    return 9'd153;
      4'd9:    return 9'd184;
      4'd10:   return 9'd214;
      4'd11:   return 9'd245;
      4'd12:   return 9'd275;
      4'd1:    return 9'd306;
      4'd2:    return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

@@ hdl/cdd_prep.sv @@
// First pipeline stage logic: shifted year and the century quotients of one date.
module cdd_prep (
  input  logic [cdd_pkg::DayW-1:0]   day,
  input  logic [cdd_pkg::MonthW-1:0] month,
  input  logic [cdd_pkg::YearW-1:0]  year,
  output cdd_pkg::prep_t             prep
);

  logic [cdd_pkg::ShiftW-1:0] yy;
  logic [cdd_pkg::QuotW-1:0]  q400_full;

  // January and February count as the end of the previous year.
  assign yy = cdd_pkg::ShiftW'(year) + cdd_pkg::YearShift
            - ((month <= cdd_pkg::MonthFeb) ? cdd_pkg::ShiftW'(1) : cdd_pkg::ShiftW'(0));

  assign q400_full = cdd_pkg::div25(cdd_pkg::DivInW'(yy >> 4));

  always_comb begin
    prep.day       = day;
    prep.month     = month;
    prep.year      = year;
    prep.yy        = yy;
    prep.year_c100 = cdd_pkg::div25(cdd_pkg::DivInW'(year >> 2));
    prep.yy_c100   = cdd_pkg::div25(cdd_pkg::DivInW'(yy >> 2));
    prep.yy_c400   = q400_full[cdd_pkg::Q400W-1:0];
  end

endmodule

@@ hdl/cdd_daynum.sv @@
// Second pipeline stage logic: date check and day number of one date.
module cdd_daynum (
  input  cdd_pkg::prep_t   prep,
  output cdd_pkg::daynum_t dn
);

  logic                      cent;
  logic                      leap;
  logic [cdd_pkg::DayW-1:0]  lim;
  logic [cdd_pkg::YearW-1:0] cent_years;

  // The year is a multiple of 100 when it equals 100 times its quotient.
  assign cent_years = cdd_pkg::YearW'(prep.year_c100) * cdd_pkg::YearW'(100);
  assign cent = (cent_years == prep.year);
  assign leap = cent ? (prep.year_c100[1:0] == 2'b00) : (prep.year[1:0] == 2'b00);

  assign lim = (prep.month == cdd_pkg::MonthFeb)
             ? (leap ? cdd_pkg::DayW'(29) : cdd_pkg::DayW'(28))
             : cdd_pkg::month_len(prep.month);

  always_comb begin
    dn.ok = (prep.month != '0) && (prep.month <= cdd_pkg::MonthDec)
         && (prep.year <= cdd_pkg::YearLimit) && (prep.day != '0) && (prep.day <= lim);
    dn.num = cdd_pkg::DaysPerYear * cdd_pkg::NumW'(prep.yy)
           + cdd_pkg::NumW'(prep.yy >> 2)
           - cdd_pkg::NumW'(prep.yy_c100)
           + cdd_pkg::NumW'(prep.yy_c400)
           + cdd_pkg::NumW'(cdd_pkg::month_offset(prep.month))
           + cdd_pkg::NumW'(prep.day) - cdd_pkg::NumW'(1);
  end

endmodule

@@ hdl/calendar_date_difference.sv @@
// Top level of the Gregorian date difference pipeline.
//
// Usage: present two dates and the include-end-day flag on the in_ ports
// with in_valid high; the request is taken at a rising edge where in_valid
// is high and in_stall is low. Each request yields exactly one result on
// the out_ ports: the signed day count from the first date to the second
// (two's complement, 23 bits) and invalid_date, which is set, with a zero
// count, when either date is out of range.
// Requests pass the register stages in order to out_valid. Throughput: one
// request per cycle while out_stall is low, set by the three register
// stages (century quotients, day numbers, subtract and sign), each of which
// takes a new request every cycle when the stage after it moves or is empty.
// Reset (rst_n low at a clock edge) empties every stage; no result is lost
// or invented across it beyond dropping the requests in flight.
// Stall: when out_stall is high the result holds on the out_ ports. Stages
// behind it keep filling bubbles, so in_stall rises only once all three
// stages hold a request; in_stall follows out_stall combinationally.
module calendar_date_difference (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cdd_pkg::DayW-1:0]          in_first_day,
  input  logic [cdd_pkg::MonthW-1:0]        in_first_month,
  input  logic [cdd_pkg::YearW-1:0]         in_first_year,
  input  logic [cdd_pkg::DayW-1:0]          in_second_day,
  input  logic [cdd_pkg::MonthW-1:0]        in_second_month,
  input  logic [cdd_pkg::YearW-1:0]         in_second_year,
  input  logic                              in_include_end_day,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cdd_pkg::NumW-1:0]   out_day_difference,
  output logic                              out_invalid_date
);

  // Stage registers: valid bits travel with their payload.
  logic             s1_v_r, s1_v_nxt;
  cdd_pkg::prep_t   s1_a_r, s1_b_r;
  logic             s1_inc_r;
  logic             s2_v_r, s2_v_nxt;
  cdd_pkg::daynum_t s2_a_r, s2_b_r;
  logic             s2_inc_r;
  logic             s3_v_r, s3_v_nxt;
  logic [cdd_pkg::NumW-1:0] s3_diff_r, s3_diff_nxt;
  logic             s3_bad_r, s3_bad_nxt;

  // A stage advances when it is empty or the stage after it advances.
  logic adv1, adv2, adv3;

  cdd_pkg::prep_t   prep_a, prep_b;
  cdd_pkg::daynum_t dn_a, dn_b;

  logic signed [cdd_pkg::NumW:0] delta;

  assign adv3 = !s3_v_r || !out_stall;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;
  assign in_stall = !adv1;

  cdd_prep u_prep_a (
    .day(in_first_day), .month(in_first_month), .year(in_first_year), .prep(prep_a)
  );
  cdd_prep u_prep_b (
    .day(in_second_day), .month(in_second_month), .year(in_second_year), .prep(prep_b)
  );

  cdd_daynum u_dn_a (.prep(s1_a_r), .dn(dn_a));
  cdd_daynum u_dn_b (.prep(s1_b_r), .dn(dn_b));

  // Valid bits: load from upstream when advancing, hold otherwise.
  always_comb begin
    s1_v_nxt = adv1 ? in_valid : s1_v_r;
    s2_v_nxt = adv2 ? s1_v_r   : s2_v_r;
    s3_v_nxt = adv3 ? s2_v_r   : s3_v_r;
  end

  // Equal dates take the negative path, so the flag subtracts there.
  always_comb begin
    delta = $signed({1'b0, s2_b_r.num}) - $signed({1'b0, s2_a_r.num});
    if (s2_a_r.num < s2_b_r.num) begin
      delta = delta + (cdd_pkg::NumW+1)'(s2_inc_r);
    end else begin
      delta = delta - (cdd_pkg::NumW+1)'(s2_inc_r);
    end
    s3_bad_nxt  = !(s2_a_r.ok && s2_b_r.ok);
    s3_diff_nxt = s3_bad_nxt ? '0 : delta[cdd_pkg::NumW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  // Payload: capture only when the stage advances, so a stall repeats nothing.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_a_r   <= prep_a;
      s1_b_r   <= prep_b;
      s1_inc_r <= in_include_end_day;
    end
    if (adv2) begin
      s2_a_r   <= dn_a;
      s2_b_r   <= dn_b;
      s2_inc_r <= s1_inc_r;
    end
    if (adv3) begin
      s3_diff_r <= s3_diff_nxt;
      s3_bad_r  <= s3_bad_nxt;
    end
  end

  assign out_valid          = s3_v_r;
  assign out_day_difference = $signed(s3_diff_r);
  assign out_invalid_date   = s3_bad_r;

endmodule
